>>> hdl/swsse_pkg.sv
// Package for the sliding window slope estimator.
// Holds the fixed widths and constants shared by all modules but swsse_mem; depends on nothing.
package swsse_pkg;

  localparam int unsigned MUL_W = 64;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned QUO_W = 33;
  localparam int unsigned X_W = 20;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned SLOPE_W = 32;

  localparam logic [X_W-1:0] X_CLAMP = {X_W{1'b1}};
  localparam logic [MUL_W-1:0] SLOPE_SCALE = 64'd15360000;
  localparam logic [CFG_W-1:0] MIN_SAMPLES_RST = 7'd60;

  localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 32'h7fff_ffff;
  localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = 32'h8000_0000;

endpackage

>>> hdl/swsse_mem.sv
// Simple dual port window memory with registered read data.
// Uses no package items.
module swsse_mem #(
  parameter int unsigned DEPTH = 120,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/swsse_mul.sv
// Shift-and-add serial multiplier, one multiplier bit per cycle.
// Depends on swsse_pkg for the operand widths.
module swsse_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [swsse_pkg::MUL_W-1:0]  a_i,
  input  logic [swsse_pkg::MUL_W-1:0]  b_i,
  output logic [swsse_pkg::PROD_W-1:0] prod_o,
  output logic                         done_o
);
  import swsse_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [PROD_W-1:0] acc_q;
  logic [PROD_W-1:0] a_q;
  logic [MUL_W-1:0]  b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q[MUL_W-1:1] == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= PROD_W'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[PROD_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MUL_W-1:1]};
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

>>> hdl/swsse_div.sv
// Restoring serial divider of a 128-bit dividend by a 64-bit divisor.
// One quotient bit per cycle; depends on swsse_pkg for the widths.
module swsse_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [swsse_pkg::PROD_W-1:0] dvd_i,
  input  logic [swsse_pkg::MUL_W-1:0]  dvs_i,
  output logic [swsse_pkg::QUO_W-1:0]  quo_o,
  output logic                         big_o,
  output logic                         done_o
);
  import swsse_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] dvd_q;
  logic [MUL_W-1:0]  dvs_q;
  logic [MUL_W-1:0]  rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic              big_q;
  logic [MUL_W-1:0]  rem_sh;
  logic [MUL_W-1:0]  rem_d;
  logic              qbit;

  always_comb begin
    rem_sh = {rem_q[MUL_W-2:0], dvd_q[PROD_W-1]};
    qbit   = rem_q[MUL_W-1] || (rem_sh >= dvs_q);
    rem_d  = qbit ? (rem_sh - dvs_q) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PROD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
      quo_q <= '0;
      big_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
      rem_q <= rem_d;
      if (quo_q[QUO_W-1]) begin
        big_q <= 1'b1;
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], qbit};
      end
    end
  end

  assign quo_o  = quo_q;
  assign big_o  = big_q | quo_q[QUO_W-1];
  assign done_o = done_q;

endmodule

>>> hdl/sliding_window_slope_estimator.sv
// Sliding window least-squares slope estimator, top level.
// A restart or a short window goes straight to the output; otherwise the window walk,
// the serial multiplier and, unless the denominator is zero, the serial divider run in
// turn, one item in flight at a time.
// Reset clears the oldest pointer, fill count and handshakes; the read pointer and the window memory are not cleared.
// Depends on swsse_pkg, swsse_mem, swsse_mul and swsse_div.
module sliding_window_slope_estimator #(
  parameter int unsigned WINDOW_DEPTH = 120,
  parameter int unsigned TEMP_WIDTH   = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [swsse_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // Fields from bit 0: temperature, elapsed_ms.
  input  logic [((TEMP_WIDTH+swsse_pkg::TIME_W+7)/8)*8-1:0] s_axis_tdata_i,
  // Fields from bit 0: action, sample_valid.
  input  logic [1:0]                              s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // Fields from bit 0: temperature_out, slope.
  output logic [((TEMP_WIDTH+swsse_pkg::SLOPE_W+7)/8)*8-1:0] m_axis_tdata_o,
  // Field: disconnect_event.
  output logic [0:0]                              m_axis_tuser_o
);
  import swsse_pkg::*;

  localparam int unsigned TW     = TEMP_WIDTH;
  localparam int unsigned AW     = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW     = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned OUT_DW = ((TW + SLOPE_W + 7) / 8) * 8;
  localparam int unsigned MEM_W  = TIME_W + TW;
  localparam int unsigned SX_W   = X_W + FW;
  localparam int unsigned SY_W   = TW + FW;
  localparam int unsigned XY_W   = X_W + 1 + TW;
  localparam int unsigned SXY_W  = XY_W + FW;
  localparam int unsigned SXX_W  = 2 * X_W + FW;

  typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_MUL, ST_DIV, ST_OUT} state_e;
  typedef enum logic [2:0] {OP_SXSY, OP_NSXY, OP_SXSX, OP_NSXX, OP_SCALE} op_e;

  state_e state_q;
  op_e    op_q;
  logic   go_q;

  logic [CFG_W-1:0] min_q;
  logic             armed_q;
  logic [AW-1:0]    oldest_q;
  logic [FW-1:0]    fill_q;

  logic [AW-1:0] rd_ptr_q;
  logic [FW-1:0] ri_q;
  logic          rv_q;
  logic          rfirst_q;
  logic [TIME_W-1:0] t0_q;
  logic          v1_q;
  logic [X_W-1:0] x1_q;
  logic signed [TW-1:0] y1_q;

  logic [SX_W-1:0]          sx_q;
  logic signed [SY_W-1:0]   sy_q;
  logic signed [SXY_W-1:0]  sxy_q;
  logic [SXX_W-1:0]         sxx_q;

  logic [MUL_W-1:0]  p1_q;
  logic [MUL_W-1:0]  num_q;
  logic [MUL_W-1:0]  nm_q;
  logic [MUL_W-1:0]  dm_q;
  logic              neg_q;
  logic [PROD_W-1:0] scaled_q;

  logic [TW-1:0]      temp_q;
  logic [SLOPE_W-1:0] slope_q;
  logic               ev_q;
  logic               ovalid_q;
  logic [TW-1:0]      otemp_q;
  logic [SLOPE_W-1:0] oslope_q;
  logic               oev_q;

  logic              in_act;
  logic              in_sv;
  logic [TW-1:0]     in_temp;
  logic [TIME_W-1:0] in_time;
  logic [TW-1:0]     temp_z;
  logic [FW:0]       ksum;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     oldest_d;
  logic [FW-1:0]     fill_d;
  logic              accept;
  logic              mem_we;
  logic [MEM_W-1:0]  rdata;
  logic [TIME_W-1:0] r_time;
  logic [TW-1:0]     r_temp;
  logic [TIME_W-1:0] t0_eff;
  logic [TIME_W-1:0] dt;
  logic [X_W-1:0]    x_c;
  logic signed [XY_W-1:0]  xy;
  logic [2*X_W-1:0]        xx;
  logic              issue;

  logic              mul_start;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              mul_done;
  logic              div_start;
  logic [QUO_W-1:0]  quo;
  logic              big;
  logic              div_done;
  logic [MUL_W-1:0]  diff;
  logic [SLOPE_W-1:0] slope_fin;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_act  = s_axis_tuser_i[0];
  assign in_sv   = s_axis_tuser_i[1];
  assign in_temp = s_axis_tdata_i[TW-1:0];
  assign in_time = s_axis_tdata_i[TW+TIME_W-1:TW];
  assign temp_z  = in_sv ? in_temp : '0;

  always_comb begin
    ksum = (FW+1)'(oldest_q) + (FW+1)'(fill_q);
    if (ksum >= (FW+1)'(WINDOW_DEPTH)) begin
      ksum = ksum - (FW+1)'(WINDOW_DEPTH);
    end
    oldest_d = oldest_q;
    fill_d   = fill_q;
    if (fill_q < FW'(WINDOW_DEPTH)) begin
      wr_addr = ksum[AW-1:0];
      fill_d  = fill_q + 1'b1;
    end else begin
      wr_addr  = oldest_q;
      oldest_d = (oldest_q == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
    end
  end

  assign mem_we = accept && !in_act;
  assign issue  = (state_q == ST_WALK) && (ri_q < fill_q);

  swsse_mem #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (MEM_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr),
    .wdata_i ({in_time, temp_z}),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign r_time = rdata[MEM_W-1:TW];
  assign r_temp = rdata[TW-1:0];
  assign t0_eff = rfirst_q ? r_time : t0_q;
  assign dt     = r_time - t0_eff;
  assign x_c    = (dt > TIME_W'(X_CLAMP)) ? X_CLAMP : dt[X_W-1:0];
  assign xy     = $signed({1'b0, x1_q}) * y1_q;
  assign xx     = x1_q * x1_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_SXSY: begin
        mul_a = MUL_W'(sy_q);
        mul_b = MUL_W'(sx_q);
      end
      OP_NSXY: begin
        mul_a = MUL_W'(sxy_q);
        mul_b = MUL_W'(fill_q);
      end
      OP_SXSX: begin
        mul_a = MUL_W'(sx_q);
        mul_b = MUL_W'(sx_q);
      end
      OP_NSXX: begin
        mul_a = MUL_W'(sxx_q);
        mul_b = MUL_W'(fill_q);
      end
      OP_SCALE: begin
        mul_a = nm_q;
        mul_b = SLOPE_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state_q == ST_MUL) && !go_q;
  assign div_start = (state_q == ST_DIV) && !go_q;
  assign diff      = p1_q - mul_prod[MUL_W-1:0];

  swsse_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  swsse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (scaled_q),
    .dvs_i   (dm_q),
    .quo_o   (quo),
    .big_o   (big),
    .done_o  (div_done)
  );

  always_comb begin
    if (neg_q) begin
      if (big || (quo > QUO_W'(SLOPE_NEG_MAX))) begin
        slope_fin = SLOPE_NEG_MAX;
      end else begin
        slope_fin = '0 - quo[SLOPE_W-1:0];
      end
    end else if (big || (quo > QUO_W'(SLOPE_POS_MAX))) begin
      slope_fin = SLOPE_POS_MAX;
    end else begin
      slope_fin = quo[SLOPE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_SXSY;
      go_q     <= 1'b0;
      min_q    <= MIN_SAMPLES_RST;
      armed_q  <= 1'b1;
      oldest_q <= '0;
      fill_q   <= '0;
      ri_q     <= '0;
      rv_q     <= 1'b0;
      rfirst_q <= 1'b0;
      v1_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        min_q <= cfg_data_i;
      end
      if (ovalid_q && m_axis_tready_i && (state_q != ST_OUT)) begin
        ovalid_q <= 1'b0;
      end
      rv_q     <= issue;
      rfirst_q <= issue && (ri_q == '0);
      v1_q     <= rv_q;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            armed_q <= in_sv;
            if (in_act) begin
              oldest_q <= '0;
              fill_q   <= '0;
              state_q  <= ST_OUT;
            end else begin
              oldest_q <= oldest_d;
              fill_q   <= fill_d;
              ri_q     <= '0;
              if (32'(fill_d) > 32'(min_q)) begin
                state_q <= ST_WALK;
              end else begin
                state_q <= ST_OUT;
              end
            end
          end
        end
        ST_WALK: begin
          if (issue) begin
            ri_q <= ri_q + 1'b1;
          end else if (!rv_q && !v1_q) begin
            op_q    <= OP_SXSY;
            go_q    <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!go_q) begin
            go_q <= 1'b1;
          end else if (mul_done) begin
            go_q <= 1'b0;
            case (op_q)
              OP_SXSY: op_q <= OP_NSXY;
              OP_NSXY: op_q <= OP_SXSX;
              OP_SXSX: op_q <= OP_NSXX;
              OP_NSXX: begin
                if (diff == '0) begin
                  state_q <= ST_OUT;
                end else begin
                  op_q <= OP_SCALE;
                end
              end
              OP_SCALE: state_q <= ST_DIV;
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_DIV: begin
          if (!go_q) begin
            go_q <= 1'b1;
          end else if (div_done) begin
            go_q    <= 1'b0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ovalid_q || m_axis_tready_i) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      temp_q   <= temp_z;
      ev_q     <= !in_sv && armed_q;
      slope_q  <= '0;
      rd_ptr_q <= oldest_d;
      sx_q     <= '0;
      sy_q     <= '0;
      sxy_q    <= '0;
      sxx_q    <= '0;
    end
    if (issue) begin
      rd_ptr_q <= (rd_ptr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (rv_q) begin
      if (rfirst_q) begin
        t0_q <= r_time;
      end
      x1_q <= x_c;
      y1_q <= r_temp;
    end
    if (v1_q) begin
      sx_q  <= sx_q + SX_W'(x1_q);
      sy_q  <= sy_q + SY_W'(y1_q);
      sxy_q <= sxy_q + SXY_W'(xy);
      sxx_q <= sxx_q + SXX_W'(xx);
    end
    if ((state_q == ST_MUL) && go_q && mul_done) begin
      case (op_q)
        OP_SXSY: p1_q <= mul_prod[MUL_W-1:0];
        OP_NSXY: begin
          num_q <= diff;
          nm_q  <= num_q[MUL_W-1] ? '0 - num_q : num_q;
        end
        OP_SXSX: begin
          p1_q <= mul_prod[MUL_W-1:0];
          nm_q <= num_q[MUL_W-1] ? '0 - num_q : num_q;
        end
        OP_NSXX: begin
          dm_q  <= diff[MUL_W-1] ? '0 - diff : diff;
          neg_q <= num_q[MUL_W-1] ^ diff[MUL_W-1];
        end
        OP_SCALE: scaled_q <= mul_prod;
        default: p1_q <= p1_q;
      endcase
    end
    if ((state_q == ST_DIV) && go_q && div_done) begin
      slope_q <= slope_fin;
    end
    if ((state_q == ST_OUT) && (!ovalid_q || m_axis_tready_i)) begin
      otemp_q  <= temp_q;
      oslope_q <= slope_q;
      oev_q    <= ev_q;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = OUT_DW'({oslope_q, otemp_q});
  assign m_axis_tuser_o  = oev_q;

endmodule

>>> verif/tb.sv
// Self-checking testbench for sliding_window_slope_estimator: a directed table, then random
// sample streams across several configuration and flow-control phases.
// Depends on swsse_pkg and the estimator RTL.
`timescale 1ns / 1ps

module tb;
  import swsse_pkg::*;

  localparam int unsigned DEPTH = 120;
  localparam bit ACT_MEASURE = 1'b0;
  localparam bit ACT_RESTART = 1'b1;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic signed [15:0] temp;
    logic [SLOPE_W-1:0] slope;
    logic               disc;
  } reading_t;

  typedef struct {
    int                 cfg;
    bit                 act;
    bit                 sv;
    logic [15:0]        temp;
    logic [TIME_W-1:0]  t;
    bit                 typed;
    reading_t           res;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [47:0]         s_axis_tdata_i = '0;
  logic [1:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [47:0]         m_axis_tdata_o;
  logic [0:0]          m_axis_tuser_o;

  sliding_window_slope_estimator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  logic [TIME_W-1:0]   win_time [DEPTH];
  logic signed [15:0]  win_temp [DEPTH];
  int unsigned         oldest;
  int unsigned         fill;
  bit                  armed;
  logic [CFG_W-1:0]    min_fill;

  reading_t            pending_readings[$];
  int                  errors = 0;
  int                  beats_in = 0;
  int                  beats_out = 0;
  int                  nonzero_slopes = 0;
  int                  src_idle = 0;
  int                  sink_stall = 0;
  bit                  hold_req = 1'b0;
  bit                  hold_seen = 1'b0;
  int                  hold_cycles = 0;
  int unsigned         quiet = 0;
  row_t                directed_rows [14];

  function automatic logic [SLOPE_W-1:0] least_squares_slope();
    logic signed [63:0] n, sx, sy, sxy, sxx, x, y, num, den;
    logic [TIME_W-1:0]  t0, d;
    logic [63:0]        nm, dm;
    logic [127:0]       quo;
    bit                 neg;
    int unsigned        k;
    n = fill; sx = 0; sy = 0; sxy = 0; sxx = 0;
    t0 = win_time[oldest];
    for (int i = 0; i < fill; i++) begin
      k = (oldest + i) % DEPTH;
      d = win_time[k] - t0;
      x = (d > X_CLAMP) ? 64'(X_CLAMP) : 64'(d);
      y = win_temp[k];
      sx += x;
      sy += y;
      sxy += x * y;
      sxx += x * x;
    end
    num = sx * sy - n * sxy;
    den = sx * sx - n * sxx;
    if (den == 0) return '0;
    nm = num[63] ? -num : num;
    dm = den[63] ? -den : den;
    quo = ({64'b0, nm} * {64'b0, SLOPE_SCALE}) / {64'b0, dm};
    neg = num[63] ^ den[63];
    if (neg) begin
      if (quo > 128'h8000_0000) return SLOPE_NEG_MAX;
      return -quo[31:0];
    end
    if (quo > 128'h7fff_ffff) return SLOPE_POS_MAX;
    return quo[31:0];
  endfunction

  function automatic reading_t predict_reading(bit act, bit sv, logic [15:0] temp,
                                               logic [TIME_W-1:0] t);
    reading_t r;
    int unsigned k;
    r.temp = sv ? temp : '0;
    r.slope = '0;
    r.disc = !sv && armed;
    armed = sv;
    if (act == ACT_RESTART) begin
      oldest = 0;
      fill = 0;
    end else begin
      if (fill < DEPTH) begin
        k = (oldest + fill) % DEPTH;
        fill++;
      end else begin
        k = oldest;
        oldest = (oldest + 1) % DEPTH;
      end
      win_time[k] = t;
      win_temp[k] = r.temp;
      if (fill > min_fill) r.slope = least_squares_slope();
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_min_samples(logic [CFG_W-1:0] value);
    bit acc;
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    min_fill = value;
  endtask

  task automatic send_sample(bit act, bit sv, logic [15:0] temp, logic [TIME_W-1:0] t,
                             bit typed, reading_t typed_res);
    int gaps;
    bit acc;
    reading_t r;
    gaps = 0;
    while ($urandom_range(99) < src_idle) gaps++;
    if (gaps > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {t, temp};
    s_axis_tuser_i <= {sv, act};
    do begin
      @(negedge clk_i);
      acc = s_axis_tready_o;
      if (acc) begin
        r = predict_reading(act, sv, temp, t);
        pending_readings.push_back(typed ? typed_res : r);
        beats_in++;
      end
      @(posedge clk_i);
    end while (!acc);
  endtask

  always @(posedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 399;
      m_axis_tready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(negedge clk_i) begin
    reading_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      beats_out++;
      if (pending_readings.size() == 0) begin
        $error("unexpected result beat: temperature_out %0d", $signed(m_axis_tdata_o[15:0]));
        errors++;
      end else begin
        e = pending_readings[0];
        pending_readings.delete(0);
        if (e.slope != 0) nonzero_slopes++;
        if (m_axis_tdata_o[15:0] !== e.temp) begin
          $error("temperature_out: expected %0d, actual %0d", e.temp,
                 $signed(m_axis_tdata_o[15:0]));
          errors++;
        end
        if (m_axis_tdata_o[47:16] !== e.slope) begin
          $error("slope: expected %0d, actual %0d", $signed(e.slope),
                 $signed(m_axis_tdata_o[47:16]));
          errors++;
        end
        if (m_axis_tuser_o[0] !== e.disc) begin
          $error("disconnect_event: expected %0b, actual %0b", e.disc, m_axis_tuser_o[0]);
          errors++;
        end
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet);
        $display("sliding_window_slope_estimator verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] now;
    logic signed [15:0] walk;
    logic [15:0] temp;
    logic [TIME_W-1:0] t;
    bit act, sv;
    int r;
    int unsigned cfg_plan [5];
    int unsigned src_plan [5];
    int unsigned sink_plan [5];
    reading_t none;

    none = '{temp: '0, slope: '0, disc: 1'b0};
    oldest = 0;
    fill = 0;
    armed = 1'b1;
    min_fill = MIN_SAMPLES_RST;

    // cfg: value to write before the row, -1 for none.
    directed_rows = '{
      '{-1, ACT_MEASURE, 1, 16'h7fff, 32'd0,       1, '{16'sh7fff, 32'd0, 1'b0}},
      '{-1, ACT_MEASURE, 0, 16'h1234, 32'd300,     1, '{16'sd0, 32'd0, 1'b1}},
      '{-1, ACT_MEASURE, 0, 16'hffff, 32'd600,     1, '{16'sd0, 32'd0, 1'b0}},
      '{-1, ACT_MEASURE, 1, 16'h8000, 32'd900,     1, '{-16'sd32768, 32'd0, 1'b0}},
      '{-1, ACT_RESTART, 0, 16'h0005, 32'hffffffff, 1, '{16'sd0, 32'd0, 1'b1}},
      '{-1, ACT_RESTART, 1, 16'd100,  32'd0,       1, '{16'sd100, 32'd0, 1'b0}},
      '{1,  ACT_MEASURE, 1, 16'd0,    32'd0,       1, '{16'sd0, 32'd0, 1'b0}},
      '{-1, ACT_MEASURE, 1, 16'd100,  32'd1000,    0, none},
      '{-1, ACT_MEASURE, 1, 16'h8000, 32'd1001,    0, none},
      '{-1, ACT_MEASURE, 1, 16'h7fff, 32'd1002,    0, none},
      '{-1, ACT_MEASURE, 1, 16'd0,    32'd1002,    0, none},
      '{-1, ACT_MEASURE, 1, 16'h0200, 32'd5,       0, none},
      '{-1, ACT_RESTART, 1, 16'd1,    32'd7,       1, '{16'sd1, 32'd0, 1'b0}},
      '{-1, ACT_MEASURE, 1, 16'd9,    32'd7,       1, '{16'sd9, 32'd0, 1'b0}}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg >= 0) write_min_samples(CFG_W'(directed_rows[i].cfg));
      send_sample(directed_rows[i].act, directed_rows[i].sv, directed_rows[i].temp,
                  directed_rows[i].t, directed_rows[i].typed, directed_rows[i].res);
    end
    // Second sample at the same time gives a zero denominator.
    send_sample(ACT_MEASURE, 1, 16'd40, 32'd7, 1, '{16'sd40, 32'd0, 1'b0});

    cfg_plan = '{60, 1, 120, 127, 30};
    src_plan = '{0, 65, 0, 7, 0};
    sink_plan = '{0, 0, 65, 7, 0};
    now = 0;
    walk = 0;
    for (int p = 0; p < 5; p++) begin
      write_min_samples(CFG_W'(cfg_plan[p]));
      src_idle = src_plan[p];
      sink_stall = sink_plan[p];
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < 220; n++) begin
        r = $urandom_range(99);
        act = (r == 0) ? ACT_RESTART : ACT_MEASURE;
        sv = ($urandom_range(99) >= 6);
        r = $urandom_range(99);
        if (act == ACT_RESTART) begin
          t = $urandom;
          now = 0;
        end else if (r < 90) begin
          now += $urandom_range(2000);
          t = now;
        end else if (r < 95) begin
          t = $urandom;
          now = t;
        end else begin
          now -= $urandom_range(500);
          t = now;
        end
        if ($urandom_range(99) < 70) begin
          walk += $signed(16'($urandom_range(100))) - 16'sd50;
          temp = walk;
        end else begin
          temp = 16'($urandom);
        end
        send_sample(act, sv, temp, t, 0, none);
      end
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b0;
    src_idle = 0;
    sink_stall = 0;
    wait_drained();
    repeat (300) @(posedge clk_i);

    $display("Covered %0d input beats and %0d result beats (%0d nonzero slopes)",
             beats_in, beats_out, nonzero_slopes);
    $display("over five threshold and flow-control phases, including a long output stall.");
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("sliding_window_slope_estimator verification clean");
    end else begin
      $display("sliding_window_slope_estimator verification failed");
    end
    $finish;
  end

endmodule
